/* hw/rtl/calendar_date_add_days_assert.svh */
// ---------------------------------------------------------------------------
// calendar_date_add_days assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef CALENDAR_DATE_ADD_DAYS_ASSERT_SVH
`define CALENDAR_DATE_ADD_DAYS_ASSERT_SVH

// consequent checked in the same cycle
`define CDA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define CDA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/cda_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cda_pkg
// Types, constants and calendar helpers for the date add block.
// ---------------------------------------------------------------------------
package cda_pkg;

	localparam int YEAR_W  = 16;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int ADD_W   = 16;
	// day plus added count never exceeds this width
	localparam int SUM_W   = ADD_W + 1;

	localparam logic OP_SET = 1'b0;
	localparam logic OP_ADD = 1'b1;

	localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd0;
	localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd11;

	localparam logic [DAY_W-1:0] DAY_ONE   = 5'd1;
	localparam logic [DAY_W-1:0] FEB_LEAP  = 5'd29;
	localparam logic [DAY_W-1:0] FEB_PLAIN = 5'd28;

	localparam logic [YEAR_W-1:0] YEAR_MAX = 16'hFFFF;

	// multiplicative inverse of 25 mod 2^16 and the divisibility bound
	localparam logic [YEAR_W-1:0] INV25       = 16'h5C29;
	localparam logic [YEAR_W-1:0] DIV25_LIMIT = 16'd2621;

	localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} state_t;

	// leap: divisible by 4, and either not by 100 or also by 400
	// given divisibility by 4: by 100 means by 25, by 400 means also by 16
	function automatic logic is_leap(input logic [YEAR_W-1:0] year);
		logic [2*YEAR_W-1:0] prod;
		logic                div25;
		prod  = year * INV25;
		div25 = (prod[YEAR_W-1:0] <= DIV25_LIMIT);
		return (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));
	endfunction

	function automatic logic [DAY_W-1:0] days_in(
		input logic [MONTH_W-1:0] month,
		input logic               leap
	);
		logic [MONTH_W-1:0] m;
		m = (month > MONTH_LAST) ? MONTH_LAST : month;
		if (m == MONTH_FEB) begin
			return leap ? FEB_LEAP : FEB_PLAIN;
		end
		return MONTH_LEN[m];
	endfunction

endpackage

/* hw/rtl/cda_item_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cda_item_if
// Input channel: set date or add days command with valid/ready.
// ---------------------------------------------------------------------------
interface cda_item_if;
	logic                             valid;
	logic                             ready;
	logic                             opcode;
	logic [cda_pkg::YEAR_W-1:0]       set_year;
	logic [cda_pkg::MONTH_W-1:0]      set_month;
	logic [cda_pkg::DAY_W-1:0]        set_day;
	logic [cda_pkg::ADD_W-1:0]        days_to_add;

	modport source (
		output valid, opcode, set_year, set_month, set_day, days_to_add,
		input  ready
	);
	modport sink (
		input  valid, opcode, set_year, set_month, set_day, days_to_add,
		output ready
	);
endinterface

/* hw/rtl/cda_result_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cda_result_if
// Output channel: current date after each command with valid/ready.
// ---------------------------------------------------------------------------
interface cda_result_if;
	logic                             valid;
	logic                             ready;
	logic [cda_pkg::YEAR_W-1:0]       out_year;
	logic [cda_pkg::MONTH_W-1:0]      out_month;
	logic [cda_pkg::DAY_W-1:0]        out_day;
	logic                             year_wrapped;

	modport source (
		output valid, out_year, out_month, out_day, year_wrapped,
		input  ready
	);
	modport sink (
		input  valid, out_year, out_month, out_day, year_wrapped,
		output ready
	);
endinterface

/* hw/rtl/calendar_date_add_days.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// calendar_date_add_days
// Gregorian date register with set and add-days commands.
// ---------------------------------------------------------------------------
// Usage:
//   item   : command transaction (opcode, set_year/month/day, days_to_add).
//            opcode set loads the date, opcode add adds days_to_add.
//   result : one transaction per command with the date after it and
//            year_wrapped, which flags a year rollover past 65535.
// Timing:
//   A command is taken only while the block is idle. One subtract/compare
//   unit strips one month length per cycle until the sum fits the current
//   month, stepping the month and year with it, and the result is then
//   registered once the output register is free; a set strips nothing and
//   goes straight to the output register. The block takes no new command
//   until the result of the last one is registered.
// Stall:
//   The result sits in an output register; a new command is accepted and
//   worked on while it waits, and finishes once the register is free.
// Reset:
//   arst_n clears the date to year 0, month 0, day 1, with no result pending.
// ---------------------------------------------------------------------------
module calendar_date_add_days (
	input  logic                clk,
	input  logic                arst_n,
	cda_item_if.sink            item,
	cda_result_if.source        result
);

	cda_pkg::state_t                 state_q;
	cda_pkg::state_t                 state_d;

	logic [cda_pkg::YEAR_W-1:0]      year_q;
	logic [cda_pkg::MONTH_W-1:0]     month_q;
	logic [cda_pkg::DAY_W-1:0]       day_q;
	logic [cda_pkg::SUM_W-1:0]       sum_q;
	logic                            add_q;
	logic                            wrap_q;
	logic                            leap_q;

	logic [cda_pkg::YEAR_W-1:0]      res_year_q;
	logic [cda_pkg::MONTH_W-1:0]     res_month_q;
	logic [cda_pkg::DAY_W-1:0]       res_day_q;
	logic                            res_wrap_q;
	logic                            res_valid_q;

	logic                            accept;
	logic [cda_pkg::DAY_W-1:0]       len;
	logic                            step;
	logic                            out_free;
	logic                            finish;
	logic [cda_pkg::MONTH_W-1:0]     set_month_sat;
	logic [cda_pkg::DAY_W-1:0]       set_day_fix;
	logic [cda_pkg::DAY_W-1:0]       final_day;

	assign accept   = item.valid && item.ready;
	assign len      = cda_pkg::days_in(month_q, leap_q);
	assign step     = add_q && (sum_q > {{(cda_pkg::SUM_W-cda_pkg::DAY_W){1'b0}}, len});
	assign out_free = !res_valid_q || result.ready;

	assign set_month_sat = (item.set_month > cda_pkg::MONTH_LAST) ? cda_pkg::MONTH_LAST
	                                                              : item.set_month;
	assign set_day_fix   = (item.set_day == '0) ? cda_pkg::DAY_ONE : item.set_day;
	// once no month fits, the sum is at most the month length
	assign final_day     = add_q ? sum_q[cda_pkg::DAY_W-1:0] : day_q;

	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		finish     = 1'b0;
		case (state_q)
			cda_pkg::ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					state_d = cda_pkg::ST_BUSY;
				end
			end
			cda_pkg::ST_BUSY: begin
				if (!step && out_free) begin
					finish  = 1'b1;
					state_d = cda_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cda_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// date registers and the shared month subtract unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q  <= '0;
			month_q <= cda_pkg::MONTH_FIRST;
			day_q   <= cda_pkg::DAY_ONE;
			add_q   <= 1'b0;
			wrap_q  <= 1'b0;
			leap_q  <= 1'b1;
		end else begin
			// registered from the year, so it lags it; a year change by a step always lands in january
			leap_q <= cda_pkg::is_leap(year_q);
			if (accept) begin
				wrap_q <= 1'b0;
				if (item.opcode == cda_pkg::OP_SET) begin
					add_q   <= 1'b0;
					year_q  <= item.set_year;
					month_q <= set_month_sat;
					day_q   <= set_day_fix;
				end else begin
					add_q <= 1'b1;
				end
			end else if (step) begin
				if (month_q == cda_pkg::MONTH_LAST) begin
					month_q <= cda_pkg::MONTH_FIRST;
					year_q  <= year_q + 1'b1;
					if (year_q == cda_pkg::YEAR_MAX) begin
						wrap_q <= 1'b1;
					end
				end else begin
					month_q <= month_q + 1'b1;
				end
			end else if (finish) begin
				day_q <= final_day;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_q <= {{(cda_pkg::SUM_W-cda_pkg::DAY_W){1'b0}}, day_q}
			       + {1'b0, item.days_to_add};
		end else if (step) begin
			sum_q <= sum_q - {{(cda_pkg::SUM_W-cda_pkg::DAY_W){1'b0}}, len};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (finish) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			res_year_q  <= year_q;
			res_month_q <= month_q;
			res_day_q   <= final_day;
			res_wrap_q  <= wrap_q;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.out_year     = res_year_q;
	assign result.out_month    = res_month_q;
	assign result.out_day      = res_day_q;
	assign result.year_wrapped = res_wrap_q;

endmodule

/* hw/rtl/cda_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cda_checker
// Port-level checks for the date add block, bound to the top level.
// ---------------------------------------------------------------------------
`include "calendar_date_add_days_assert.svh"

module cda_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	input  logic                             item_ready,
	input  logic                             res_valid,
	input  logic                             res_ready,
	input  logic [cda_pkg::YEAR_W-1:0]       out_year,
	input  logic [cda_pkg::MONTH_W-1:0]      out_month,
	input  logic [cda_pkg::DAY_W-1:0]        out_day,
	input  logic                             year_wrapped
);

	// a stalled result transaction stays offered
	`CDA_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")

	// and keeps its payload
	`CDA_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(out_year) && $stable(out_month) && $stable(out_day) && $stable(year_wrapped), "result payload changed while stalled")

	// every reported date is normalized in month and nonzero in day
	`CDA_ASSERT_SAME(a_res_range, res_valid, (out_month <= cda_pkg::MONTH_LAST) && (out_day != '0), "result date out of range")

	// a command transaction is worked on before the next one is taken
	`CDA_ASSERT_NEXT(a_one_at_a_time, item_valid && item_ready, !item_ready, "command taken while busy")

endmodule

bind calendar_date_add_days cda_checker u_cda_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.out_year     (result.out_year),
	.out_month    (result.out_month),
	.out_day      (result.out_day),
	.year_wrapped (result.year_wrapped)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Date add block check: directed and random set/add transactions, each
// result compared with a calendar predictor, under random stalls on both sides.
// ---------------------------------------------------------------------------
module testbench;
	import cda_pkg::*;

	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_CYCLES = 50;
	localparam int unsigned MAX_SHOWN    = 10;

	typedef struct packed {
		logic               op;
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [ADD_W-1:0]   span;
	} date_cmd_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic               wrapped;
	} date_res_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	cda_item_if   cmd_ch ();
	cda_result_if date_ch ();

	calendar_date_add_days dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (cmd_ch),
		.result (date_ch)
	);

	always #4 clk = ~clk;

	// predicted calendar state, advanced at each accepted command
	logic [YEAR_W-1:0]  cal_year  = '0;
	logic [MONTH_W-1:0] cal_month = MONTH_FIRST;
	logic [DAY_W-1:0]   cal_day   = DAY_ONE;

	date_res_t   pending_dates[$];
	int unsigned fail_count = 0;
	bit          idle_on    = 1'b1;
	bit          hold_req   = 1'b0;

	function automatic logic leap_year(input logic [YEAR_W-1:0] y);
		int unsigned yy;
		yy = y;
		return (yy % 400 == 0) || ((yy % 4 == 0) && (yy % 100 != 0));
	endfunction

	function automatic logic [DAY_W-1:0] month_days(
		input logic [YEAR_W-1:0]  y,
		input logic [MONTH_W-1:0] m
	);
		case (m)
			MONTH_FEB:               return leap_year(y) ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10: return 5'd30;
			default:                 return 5'd31;
		endcase
	endfunction

	function automatic date_res_t advance_calendar(input date_cmd_t c);
		date_res_t        r;
		logic [SUM_W-1:0] sum;
		logic [DAY_W-1:0] len;
		r.wrapped = 1'b0;
		if (c.op == OP_SET) begin
			cal_year  = c.year;
			cal_month = (c.month > MONTH_LAST) ? MONTH_LAST : c.month;
			cal_day   = (c.day == '0) ? DAY_ONE : c.day;
		end else begin
			sum = SUM_W'(cal_day) + SUM_W'(c.span);
			len = month_days(cal_year, cal_month);
			// strip one month length at a time
			while (sum > SUM_W'(len)) begin
				sum = sum - SUM_W'(len);
				if (cal_month == MONTH_LAST) begin
					cal_month = MONTH_FIRST;
					if (cal_year == YEAR_MAX) begin
						r.wrapped = 1'b1;
					end
					cal_year = cal_year + 1'b1;
				end else begin
					cal_month = cal_month + 1'b1;
				end
				len = month_days(cal_year, cal_month);
			end
			cal_day = DAY_W'(sum);
		end
		r.year  = cal_year;
		r.month = cal_month;
		r.day   = cal_day;
		return r;
	endfunction

	task automatic send_cmd(
		input logic               op,
		input logic [YEAR_W-1:0]  y,
		input logic [MONTH_W-1:0] m,
		input logic [DAY_W-1:0]   d,
		input logic [ADD_W-1:0]   n
	);
		date_cmd_t c;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		cmd_ch.valid       <= 1'b1;
		cmd_ch.opcode      <= op;
		cmd_ch.set_year    <= y;
		cmd_ch.set_month   <= m;
		cmd_ch.set_day     <= d;
		cmd_ch.days_to_add <= n;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		c.op    = op;
		c.year  = y;
		c.month = m;
		c.day   = d;
		c.span  = n;
		pending_dates.push_back(advance_calendar(c));
	endtask

	// adds straight out of reset, year 0 being a leap year
	task automatic test_reset_state();
		send_cmd(OP_ADD, 16'd0, 4'd0, 5'd0, 16'd0);
		send_cmd(OP_ADD, 16'd0, 4'd0, 5'd0, 16'd59);
	endtask

	// month saturation, day zero, and days past the month end
	task automatic test_set_fields();
		send_cmd(OP_SET, 16'd2023, 4'd15, 5'd0, 16'd0);
		send_cmd(OP_ADD, 16'd0, 4'd0, 5'd0, 16'd30);
		send_cmd(OP_SET, 16'd12345, 4'd12, 5'd16, 16'hFFFF);
		send_cmd(OP_SET, 16'd2023, MONTH_FEB, 5'd31, 16'd0);
		send_cmd(OP_ADD, 16'd0, 4'd0, 5'd0, 16'd0);
		send_cmd(OP_SET, 16'd2023, 4'd3, 5'd31, 16'd0);
		send_cmd(OP_ADD, 16'hFFFF, 4'd15, 5'd31, 16'd0);
	endtask

	task automatic test_leap_years();
		send_cmd(OP_SET, 16'd1900, MONTH_FEB, 5'd28, 16'd0);
		send_cmd(OP_ADD, 16'd0, 4'd0, 5'd0, 16'd1);
		send_cmd(OP_SET, 16'd2000, MONTH_FEB, 5'd28, 16'd0);
		send_cmd(OP_ADD, 16'd0, 4'd0, 5'd0, 16'd1);
		send_cmd(OP_SET, 16'd2024, MONTH_FEB, 5'd28, 16'd0);
		send_cmd(OP_ADD, 16'd0, 4'd0, 5'd0, 16'd2);
		send_cmd(OP_SET, 16'd2100, MONTH_FEB, 5'd28, 16'd0);
		send_cmd(OP_ADD, 16'd0, 4'd0, 5'd0, 16'd1);
	endtask

	task automatic test_year_wrap();
		send_cmd(OP_SET, YEAR_MAX, MONTH_LAST, 5'd31, 16'd0);
		send_cmd(OP_ADD, 16'd0, 4'd0, 5'd0, 16'd1);
		send_cmd(OP_SET, YEAR_MAX, MONTH_FIRST, DAY_ONE, 16'd0);
		send_cmd(OP_ADD, 16'd0, 4'd0, 5'd0, 16'hFFFF);
	endtask

	task automatic test_full_span();
		send_cmd(OP_SET, 16'd0, MONTH_FIRST, DAY_ONE, 16'd0);
		send_cmd(OP_ADD, 16'd0, 4'd0, 5'd0, 16'hFFFF);
	endtask

	// receiver holds off while commands keep coming, so the input stalls
	task automatic test_output_stall();
		bit saved_idle;
		saved_idle = idle_on;
		idle_on    = 1'b0;
		hold_req   = 1'b1;
		repeat (8) send_cmd(OP_ADD, 16'd0, 4'd0, 5'd0, ADD_W'($urandom_range(0, 90)));
		idle_on = saved_idle;
	endtask

	task automatic test_random(input int unsigned n_cmds);
		int unsigned        sent;
		int unsigned        pick;
		logic [YEAR_W-1:0]  y;
		logic [MONTH_W-1:0] m;
		logic [DAY_W-1:0]   d;
		logic [ADD_W-1:0]   n;
		sent = 0;
		while (sent < n_cmds) begin
			// mostly a set followed by a run of adds, sometimes adds alone
			if ($urandom_range(0, 3) != 0) begin
				pick = $urandom_range(0, 7);
				if (pick == 0) begin
					y = YEAR_W'($urandom_range(65530, 65535));
				end else if (pick == 1) begin
					y = YEAR_W'($urandom_range(0, 3));
				end else if (pick < 4) begin
					y = YEAR_W'(100 * $urandom_range(15, 25) + $urandom_range(0, 4) - 2);
				end else begin
					y = YEAR_W'($urandom_range(0, 65535));
				end
				m = ($urandom_range(0, 9) == 0) ? MONTH_W'($urandom_range(12, 15))
					: MONTH_W'($urandom_range(0, 11));
				pick = $urandom_range(0, 15);
				if (pick == 0) begin
					d = '0;
				end else if (pick < 4) begin
					d = DAY_W'($urandom_range(28, 31));
				end else begin
					d = DAY_W'($urandom_range(1, 28));
				end
				send_cmd(OP_SET, y, m, d, ADD_W'($urandom_range(0, 65535)));
				sent++;
			end
			repeat ($urandom_range(1, 6)) begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					n = ADD_W'($urandom_range(0, 31));
				end else if (pick < 80) begin
					n = ADD_W'($urandom_range(0, 400));
				end else if (pick < 95) begin
					n = ADD_W'($urandom_range(0, 3000));
				end else begin
					n = ADD_W'($urandom_range(0, 65535));
				end
				send_cmd(OP_ADD, YEAR_W'($urandom_range(0, 65535)),
					MONTH_W'($urandom_range(0, 15)), DAY_W'($urandom_range(0, 31)), n);
				sent++;
			end
		end
	endtask

	// receiver: random ready bursts, plus one long hold on request
	initial begin
		int unsigned run_left;
		bit          run_ready;
		run_left  = 0;
		run_ready = 1'b0;
		date_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				run_ready = 1'b0;
				run_left  = HOLD_CYCLES;
			end else if (run_left == 0) begin
				if (idle_on && $urandom_range(0, 2) == 0) begin
					run_ready = 1'b0;
					run_left  = $urandom_range(1, 19);
				end else begin
					run_ready = 1'b1;
					run_left  = $urandom_range(1, 40);
				end
			end
			run_left--;
			date_ch.ready <= run_ready;
		end
	end

	// result check against the oldest predicted date
	always @(posedge clk) begin
		date_res_t want;
		if (arst_n && date_ch.valid && date_ch.ready) begin
			if (pending_dates.size() == 0) begin
				if (fail_count < MAX_SHOWN) begin
					$display("%0t: unexpected transaction %0d-%0d-%0d wrap %0b", $realtime,
						date_ch.out_year, date_ch.out_month, date_ch.out_day,
						date_ch.year_wrapped);
				end
				fail_count++;
			end else begin
				want = pending_dates.pop_front();
				if (date_ch.out_year !== want.year || date_ch.out_month !== want.month
					|| date_ch.out_day !== want.day
					|| date_ch.year_wrapped !== want.wrapped) begin
					if (fail_count < MAX_SHOWN) begin
						$display("%0t: expected %0d-%0d-%0d wrap %0b, got %0d-%0d-%0d wrap %0b",
							$realtime, want.year, want.month, want.day, want.wrapped,
							date_ch.out_year, date_ch.out_month, date_ch.out_day,
							date_ch.year_wrapped);
					end
					fail_count++;
				end
			end
		end
	end

	initial begin
		cmd_ch.valid       <= 1'b0;
		cmd_ch.opcode      <= OP_SET;
		cmd_ch.set_year    <= '0;
		cmd_ch.set_month   <= '0;
		cmd_ch.set_day     <= '0;
		cmd_ch.days_to_add <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_set_fields();
		test_leap_years();
		test_year_wrap();
		test_full_span();
		test_output_stall();
		test_random(1300);
		idle_on = 1'b0;
		test_random(200);
		cmd_ch.valid <= 1'b0;
		while (pending_dates.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#150_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

/* calendar_date_add_days.f */
+incdir+hw/rtl
hw/rtl/cda_pkg.sv
hw/rtl/cda_item_if.sv
hw/rtl/cda_result_if.sv
hw/rtl/calendar_date_add_days.sv
hw/rtl/cda_checker.sv
tb/sv/testbench.sv
